FILE: hdl/kwf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwf_pkg
// shared types and constants of the k-weighting filter: coefficient
// register map, reset coefficients, multiplier select codes and the
// command word that the controller hands to the datapath
// ----------------------------------------------------------------------------
package kwf_pkg;

  localparam int COEF_WIDTH      = 32;
  localparam int NUM_REGS        = 8;
  localparam int REG_INDEX_WIDTH = $clog2(NUM_REGS);
  localparam int CFG_INDEX_WIDTH = REG_INDEX_WIDTH + 1;

  // multiplier select, the code doubles as the coefficient register index
  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    SEL_SHELF_B0 = 3'd0,
    SEL_SHELF_B1 = 3'd1,
    SEL_SHELF_B2 = 3'd2,
    SEL_SHELF_A1 = 3'd3,
    SEL_SHELF_A2 = 3'd4,
    SEL_HP_GAIN  = 3'd5,
    SEL_HP_A1    = 3'd6,
    SEL_HP_A2    = 3'd7
  } mac_sel_t;

  // 48 kHz coefficients, signed q3.29
  localparam logic signed [COEF_WIDTH-1:0] COEF_RESET [NUM_REGS] = '{
    32'sd824163883,
    -32'sd1445093387,
    32'sd643382241,
    -32'sd907665797,
    32'sd393247621,
    32'sd536870912,
    -32'sd1068398593,
    32'sd531540991
  };

  typedef struct packed {
    logic     idle;        // ready for the next item
    logic     x_load;      // capture the incoming sample
    logic     acc_clear;   // zero the accumulator
    logic     mul_en;      // multiply coefficient and operand chosen by sel
    mac_sel_t sel;
    logic     shelf_done;  // round and saturate shelf, shift shelf history
    logic     diff_load;   // form the second difference for the high-pass
    logic     hp_done;     // round and saturate result, shift high-pass history
  } kwf_cmd_t;

  typedef struct packed {
    logic out_blocked;     // result register full and stalled
  } kwf_stat_t;

endpackage

`default_nettype wire

FILE: hdl/kwf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwf_ctrl
// sequencer for one item: five shelf products, round, second difference,
// three high-pass products, round and hand-off to the result register
// ----------------------------------------------------------------------------
module kwf_ctrl import kwf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      sample_valid,
  input  wire kwf_stat_t stat,
  output kwf_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SHELF_MAC,
    SHELF_END,
    SHELF_ROUND,
    HP_DIFF,
    HP_MAC,
    HP_END,
    HP_ROUND
  } state_t;

  localparam logic [2:0] SHELF_LAST = 3'd4;
  localparam logic [2:0] HP_LAST    = 3'd2;

  state_t     state;
  logic [2:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          step <= '0;
          if (sample_valid) state <= SHELF_MAC;
        end
        SHELF_MAC: begin
          if (step == SHELF_LAST) begin
            step  <= '0;
            state <= SHELF_END;
          end else begin
            step <= step + 3'd1;
          end
        end
        SHELF_END:   state <= SHELF_ROUND;
        SHELF_ROUND: state <= HP_DIFF;
        HP_DIFF: begin
          step  <= '0;
          state <= HP_MAC;
        end
        HP_MAC: begin
          if (step == HP_LAST) begin
            step  <= '0;
            state <= HP_END;
          end else begin
            step <= step + 3'd1;
          end
        end
        HP_END: state <= HP_ROUND;
        HP_ROUND: begin
          if (!stat.out_blocked) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.sel        = SEL_SHELF_B0;
    cmd.idle       = (state == IDLE);
    unique case (state)
      IDLE: begin
        cmd.x_load    = sample_valid;
        cmd.acc_clear = sample_valid;
      end
      SHELF_MAC: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = mac_sel_t'(step);
      end
      SHELF_ROUND: cmd.shelf_done = 1'b1;
      HP_DIFF: begin
        cmd.diff_load = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      HP_MAC: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = mac_sel_t'(SEL_HP_GAIN + step);
      end
      HP_ROUND: cmd.hp_done = !stat.out_blocked;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/kwf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwf_datapath
// coefficient registers, filter histories, one shared multiplier with a
// product register, accumulator, rounding and saturation, result register
// ----------------------------------------------------------------------------
module kwf_datapath import kwf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 29
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire kwf_cmd_t                          cmd,
  output kwf_stat_t                              stat,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  wire logic                              cfg_we,
  input  wire logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic        [COEF_WIDTH-1:0]      cfg_data,
  input  wire logic                              weighted_stall,
  output logic                                   weighted_valid,
  output logic signed [SAMPLE_WIDTH-1:0]         weighted_out
);

  localparam int IW    = SAMPLE_WIDTH + 4;     // value between sections
  localparam int DW    = IW + 3;               // second difference
  localparam int PW    = COEF_WIDTH + DW;      // product
  localparam int ACC_W = PW + 2;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] IN_MAX =
    {{(ACC_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] IN_MIN = ~IN_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [COEF_WIDTH-1:0]   coef [NUM_REGS];
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [SAMPLE_WIDTH-1:0] sx0, sx1, hy0, hy1;
  logic signed [IW-1:0]           sy0, sy1, hx0, hx1;
  logic signed [IW-1:0]           s_reg;
  logic signed [DW-1:0]           d_reg;
  logic signed [PW-1:0]           prod;
  logic                           prod_valid;
  logic                           prod_neg;
  logic signed [ACC_W-1:0]        acc;

  logic signed [DW-1:0]           operand;
  logic signed [COEF_WIDTH-1:0]   coef_sel;
  logic                           neg_sel;
  logic signed [ACC_W-1:0]        rounded;
  logic signed [IW-1:0]           s_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index < CFG_INDEX_WIDTH'(NUM_REGS));

  // operand and sign for the current product
  always_comb begin
    unique case (cmd.sel)
      SEL_SHELF_B0: operand = DW'(x_reg);
      SEL_SHELF_B1: operand = DW'(sx0);
      SEL_SHELF_B2: operand = DW'(sx1);
      SEL_SHELF_A1: operand = DW'(sy0);
      SEL_SHELF_A2: operand = DW'(sy1);
      SEL_HP_GAIN:  operand = d_reg;
      SEL_HP_A1:    operand = DW'(hy0);
      SEL_HP_A2:    operand = DW'(hy1);
      default:      operand = '0;
    endcase
    neg_sel  = (cmd.sel == SEL_SHELF_A1) || (cmd.sel == SEL_SHELF_A2) ||
               (cmd.sel == SEL_HP_A1) || (cmd.sel == SEL_HP_A2);
    coef_sel = coef[cmd.sel];
  end

  // round half up, then saturate
  always_comb begin
    rounded = (acc + RND) >>> COEF_FRAC_BITS;
    if (rounded > IN_MAX)      s_sat = IW'(IN_MAX);
    else if (rounded < IN_MIN) s_sat = IW'(IN_MIN);
    else                       s_sat = IW'(rounded);
    if (rounded > OUT_MAX)      y_sat = SAMPLE_WIDTH'(OUT_MAX);
    else if (rounded < OUT_MIN) y_sat = SAMPLE_WIDTH'(OUT_MIN);
    else                        y_sat = SAMPLE_WIDTH'(rounded);
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) coef[i] <= COEF_RESET[i];
    end else if (cfg_hit) begin
      coef[cfg_index[REG_INDEX_WIDTH-1:0]] <= cfg_data;
    end
  end

  // multiply into the product register, then accumulate in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_en;
    end
    if (cmd.mul_en) begin
      prod     <= coef_sel * operand;
      prod_neg <= neg_sel;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      if (prod_neg) acc <= acc - ACC_W'(prod);
      else          acc <= acc + ACC_W'(prod);
    end
    if (cmd.x_load) x_reg <= sample_in;
    if (cmd.shelf_done) s_reg <= s_sat;
    if (cmd.diff_load) d_reg <= DW'(s_reg) - (DW'(hx0) <<< 1) + DW'(hx1);
  end

  // filter histories, cleared by reset and by any coefficient write
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      sx0 <= '0;
      sx1 <= '0;
      sy0 <= '0;
      sy1 <= '0;
      hx0 <= '0;
      hx1 <= '0;
      hy0 <= '0;
      hy1 <= '0;
    end else begin
      if (cmd.shelf_done) begin
        sx1 <= sx0;
        sx0 <= x_reg;
        sy1 <= sy0;
        sy0 <= s_sat;
      end
      if (cmd.hp_done) begin
        hx1 <= hx0;
        hx0 <= s_reg;
        hy1 <= hy0;
        hy0 <= y_sat;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_valid <= 1'b0;
    end else if (cmd.hp_done) begin
      weighted_valid <= 1'b1;
    end else if (!weighted_stall) begin
      weighted_valid <= 1'b0;
    end
    if (cmd.hp_done) weighted_out <= y_sat;
  end

  assign stat.out_blocked = weighted_valid && weighted_stall;

endmodule

`default_nettype wire

FILE: hdl/k_weighting_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_weighting_filter
// loudness-meter k-weighting: high-frequency shelf followed by high-pass
// ----------------------------------------------------------------------------
// Each signed sample item goes through a second-order shelf and then a
// second-order high-pass, both direct form I with a0 = 1, and leaves as one
// K-weighted, saturated sample. One shared 32-bit multiplier does all eight
// products, so an item holds the controller from the accepting state
// through five shelf products, a drain and round, the high-pass second
// difference, three high-pass products and a last drain and round that
// loads the result register. The next item is taken as soon as the
// controller returns to idle, even while the last result still waits in
// its register; the result is held back only when that register is still
// full and stalled. Coefficients are signed q3.29 registers that reset to
// the 48 kHz values; writing any of them clears the filter history, writes
// to indexes past the last register are dropped. The config port is ready
// only while no item is in progress.
// ----------------------------------------------------------------------------
module k_weighting_filter import kwf_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 29
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample items
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  // weighted result items
  output logic                                   weighted_valid,
  input  wire logic                              weighted_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         weighted_out,
  // coefficient writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic        [COEF_WIDTH-1:0]      cfg_data
);

  kwf_cmd_t  cmd;
  kwf_stat_t stat;
  logic      cfg_we;

  // item in only while idle, config likewise
  assign sample_stall = !cmd.idle;
  assign cfg_ready    = cmd.idle;
  assign cfg_we       = cfg_valid && cfg_ready;

  kwf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .stat         (stat),
    .cmd          (cmd)
  );

  kwf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .sample_in      (sample_in),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .weighted_stall (weighted_stall),
    .weighted_valid (weighted_valid),
    .weighted_out   (weighted_out)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// k-weighting filter: directed table, then random phases over coefficient sets
// ----------------------------------------------------------------------------
// Sample items go in on a valid/stall channel and weighted results come back
// on another one. An in-bench fixed-point model of the shelf and high-pass
// sections predicts each result not typed into the table. Coefficients are
// rewritten between phases while the filter is idle. Both sides idle and
// stall at random, with bursts of back-to-back traffic. Once the result
// side holds off for a long stretch so the filter backs up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import kwf_pkg::*;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 29;
  localparam int INNER_WIDTH    = SAMPLE_WIDTH + 4;

  localparam int NUM_PHASES      = 8;
  localparam int PHASE_ITEMS     = 160;
  localparam int SETTLE_CYCLES   = 20;    // longer than one item's trip through the filter
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 2000;  // cycles without any handshake
  localparam int MAX_REPORTS     = 10;

  localparam logic [COEF_WIDTH-1:0] ONE_Q29  = 32'h2000_0000;
  localparam logic [COEF_WIDTH-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_WIDTH-1:0] COEF_MIN = 32'h8000_0000;
  // first index past the coefficient map, the filter drops writes there
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAST_END = CFG_INDEX_WIDTH'(NUM_REGS);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // one row of the directed table: a sample item or a coefficient write
  typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [CFG_INDEX_WIDTH-1:0]        index;
    logic [COEF_WIDTH-1:0]             data;   // sample in the low bits, or coefficient
    logic                              fixed;  // result typed in below
    logic signed [SAMPLE_WIDTH-1:0]    want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 33;

  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // silence right after reset gives silence
    '{ROW_SAMPLE, '0, 32'sd0,        1'b1, 24'sd0},
    // full-scale steps through the 48 kHz filter
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, -32'sd8388608, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, -32'sd1,       1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd1,        1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0},
    // shelf becomes a wire, high-pass a bare second difference
    '{ROW_COEF, SEL_SHELF_B0, ONE_Q29, 1'b0, 24'sd0},
    '{ROW_COEF, SEL_SHELF_B1, '0,      1'b0, 24'sd0},
    '{ROW_COEF, SEL_SHELF_B2, '0,      1'b0, 24'sd0},
    '{ROW_COEF, SEL_SHELF_A1, '0,      1'b0, 24'sd0},
    '{ROW_COEF, SEL_SHELF_A2, '0,      1'b0, 24'sd0},
    '{ROW_COEF, SEL_HP_GAIN,  ONE_Q29, 1'b0, 24'sd0},
    '{ROW_COEF, SEL_HP_A1,    '0,      1'b0, 24'sd0},
    '{ROW_COEF, SEL_HP_A2,    '0,      1'b0, 24'sd0},
    // x, x - 2x, x - 2x + x, then a difference that saturates low
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b1, 24'sd8388607},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b1, -24'sd8388607},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b1, 24'sd0},
    '{ROW_SAMPLE, '0, -32'sd8388608, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, '0, 32'sd12345,    1'b0, 24'sd0},
    // largest shelf gain, output saturates high
    '{ROW_COEF, SEL_SHELF_B0, COEF_MAX, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b1, 24'sd8388607},
    // most negative high-pass gain, output saturates low
    '{ROW_COEF, SEL_HP_GAIN, COEF_MIN, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b1, -24'sd8388608},
    // unstable shelf feedback drives the inner value into saturation
    '{ROW_COEF, SEL_SHELF_A1, COEF_MIN, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0},
    // write past the map is dropped and the history survives it
    '{ROW_COEF, REG_PAST_END, '0,     1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, -32'sd8388608, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd0,        1'b0, 24'sd0},
    // most negative shelf gain
    '{ROW_COEF, SEL_SHELF_B0, COEF_MIN, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, -32'sd8388608, 1'b0, 24'sd0},
    '{ROW_SAMPLE, '0, 32'sd8388607,  1'b0, 24'sd0}
  };

  // dut ports, inputs known from time zero
  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              sample_valid   = 1'b0;
  logic                              sample_stall;
  logic signed [SAMPLE_WIDTH-1:0]    sample_in      = '0;
  logic                              weighted_valid;
  logic                              weighted_stall = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0]    weighted_out;
  logic                              cfg_valid      = 1'b0;
  logic                              cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index      = '0;
  logic [COEF_WIDTH-1:0]             cfg_data       = '0;

  // filter model state: coefficients and the four histories
  logic signed [COEF_WIDTH-1:0]      coef_q29  [NUM_REGS];
  logic signed [SAMPLE_WIDTH-1:0]    shelf_x   [2];
  logic signed [INNER_WIDTH-1:0]     shelf_y   [2];
  logic signed [INNER_WIDTH-1:0]     hp_x      [2];
  logic signed [SAMPLE_WIDTH-1:0]    hp_y      [2];

  logic signed [SAMPLE_WIDTH-1:0]    weighted_expected [$];

  int  mismatches     = 0;
  int  idle_cycles    = 0;
  int  send_burst     = 0;
  int  recv_burst     = 0;
  bit  holdoff_wanted = 1'b0;
  bit  holdoff_done   = 1'b0;

  k_weighting_filter #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_in      (sample_in),
    .weighted_valid (weighted_valid),
    .weighted_stall (weighted_stall),
    .weighted_out   (weighted_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // filter model
  // --------------------------------------------------------------------------

  function automatic void clear_history();
    for (int i = 0; i < 2; i++) begin
      shelf_x[i] = '0;
      shelf_y[i] = '0;
      hp_x[i]    = '0;
      hp_y[i]    = '0;
    end
  endfunction

  function automatic void coef_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                     input logic [COEF_WIDTH-1:0] data);
    if (idx < NUM_REGS) begin
      coef_q29[idx[REG_INDEX_WIDTH-1:0]] = data;
      clear_history();
    end
  endfunction

  // round half up out of q.29, then clamp to w bits signed
  function automatic longint round_sat(input longint acc, input int w);
    longint v;
    longint top;
    v   = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) v = top;
    else if (v < -top - 1) v = -top - 1;
    return v;
  endfunction

  // one sample through shelf then high-pass; sums stay well inside 64 bits
  function automatic logic signed [SAMPLE_WIDTH-1:0] k_weight(
    input logic signed [SAMPLE_WIDTH-1:0] x
  );
    longint acc;
    longint shelf;
    longint diff;
    longint y;
    acc = longint'(coef_q29[SEL_SHELF_B0]) * longint'(x)
        + longint'(coef_q29[SEL_SHELF_B1]) * longint'(shelf_x[0])
        + longint'(coef_q29[SEL_SHELF_B2]) * longint'(shelf_x[1])
        - longint'(coef_q29[SEL_SHELF_A1]) * longint'(shelf_y[0])
        - longint'(coef_q29[SEL_SHELF_A2]) * longint'(shelf_y[1]);
    shelf = round_sat(acc, INNER_WIDTH);
    shelf_x[1] = shelf_x[0];
    shelf_x[0] = x;
    shelf_y[1] = shelf_y[0];
    shelf_y[0] = INNER_WIDTH'(shelf);

    diff = shelf - 2 * longint'(hp_x[0]) + longint'(hp_x[1]);
    acc = longint'(coef_q29[SEL_HP_GAIN]) * diff
        - longint'(coef_q29[SEL_HP_A1]) * longint'(hp_y[0])
        - longint'(coef_q29[SEL_HP_A2]) * longint'(hp_y[1]);
    y = round_sat(acc, SAMPLE_WIDTH);
    hp_x[1] = hp_x[0];
    hp_x[0] = INNER_WIDTH'(shelf);
    hp_y[1] = hp_y[0];
    hp_y[0] = SAMPLE_WIDTH'(y);
    return SAMPLE_WIDTH'(y);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offer one sample item after a random gap, predict its result on accept
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                             input logic fixed,
                             input logic signed [SAMPLE_WIDTH-1:0] want);
    int gap;
    logic signed [SAMPLE_WIDTH-1:0] predicted;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(15, 0) == 0) send_burst = $urandom_range(40, 10);
      gap = $urandom_range(16, 0);
    end
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_in    <= x;
    do @(posedge clk); while (sample_stall);
    predicted = k_weight(x);
    weighted_expected.push_back(fixed ? want : predicted);
  endtask

  // stop offering, let every pending result come back and the filter go idle
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (weighted_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // coefficient writes only happen on an idle filter
  task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx,
                            input logic [COEF_WIDTH-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    coef_write(idx, data);
  endtask

  // coefficient set per phase: standard, nudged standard, random, extremes
  task automatic configure_phase(input int phase);
    logic [COEF_WIDTH-1:0] value;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (phase % 4)
        0: value = COEF_RESET[r];
        1: value = COEF_RESET[r] + 32'($urandom_range(65535, 0)) - 32'd32768;
        2: value = $urandom;
        default: begin
          case ($urandom_range(3, 0))
            0:       value = COEF_MAX;
            1:       value = COEF_MIN;
            2:       value = '0;
            default: value = ONE_Q29;
          endcase
        end
      endcase
      write_coef(CFG_INDEX_WIDTH'(r), value);
    end
  endtask

  // mostly full-range noise, some quiet signal, some full-scale values
  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(9, 0))
      0:       return $urandom_range(1, 0) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3: return SAMPLE_WIDTH'(int'($urandom_range(2046, 0)) - 1023);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    coef_q29 = COEF_RESET;
    clear_history();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_COEF)
        write_coef(DIRECTED[i].index, DIRECTED[i].data);
      else
        send_sample(SAMPLE_WIDTH'(DIRECTED[i].data), DIRECTED[i].fixed, DIRECTED[i].want);
    end

    // random phases, each with its own coefficient set
    for (int p = 0; p < NUM_PHASES; p++) begin
      configure_phase(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off on the result side while items keep coming
        if (p == 1 && n == 40) holdoff_wanted = 1'b1;
        // mid-phase pause until all results are back, plus a dropped write
        if (n == PHASE_ITEMS / 2)
          write_coef(CFG_INDEX_WIDTH'($urandom_range((1 << CFG_INDEX_WIDTH) - 1, NUM_REGS)),
                     $urandom);
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    // wait out the last results and a little more for strays
    sample_valid <= 1'b0;
    while (weighted_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[k_weighting_filter] OK");
    else
      $display("[k_weighting_filter] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random stall per item, bursts, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_wanted && !holdoff_done) begin
        wait_cycles  = HOLD_OFF_CYCLES;
        holdoff_done = 1'b1;
      end else if (recv_burst > 0) begin
        recv_burst--;
        wait_cycles = 0;
      end else begin
        if ($urandom_range(15, 0) == 0) recv_burst = $urandom_range(40, 10);
        wait_cycles = $urandom_range(16, 0);
      end
      if (wait_cycles != 0) begin
        weighted_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      weighted_stall <= 1'b0;
      do @(posedge clk); while (!weighted_valid);
    end
  end

  // --------------------------------------------------------------------------
  // result check against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (!rst && weighted_valid && !weighted_stall) begin
      if (weighted_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d arrived with nothing pending", $time, weighted_out);
      end else begin
        want = weighted_expected.pop_front();
        if (weighted_out !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: weighted_out expected %0d, got %0d", $time, want, weighted_out);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: any handshake counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (weighted_valid && !weighted_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[k_weighting_filter] ERROR");
        $finish;
      end
    end
  end

endmodule
